// ===== rtl/kms_pkg.sv =====
`default_nettype none

package kms_pkg;

    localparam int VALUE_W = 32;
    localparam int WAY_W   = 4;
    localparam int CFG_W   = 5;

    localparam logic [CFG_W-1:0] WAYS_IN_USE_RST = 5'd16;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;        // take a load beat
        logic scan_clear;  // take a pop beat, rewind the scan
        logic scan_step;   // issue the next head read
        logic emit;        // move the winner to the result register
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;   // current scan index is the last one in use
        logic out_full;    // result register still holds an untaken beat
    } ctrl_sts_t;

endpackage

`default_nettype wire

// ===== rtl/kms_in_if.sv =====
`default_nettype none

interface kms_in_if;
    logic                               valid;
    logic                               ready;
    logic                               mode;
    logic [kms_pkg::WAY_W-1:0]          way;
    logic signed [kms_pkg::VALUE_W-1:0] value;
    logic                               way_empty;

    modport source (output valid, output mode, output way, output value,
                    output way_empty, input ready);
    modport sink   (input valid, input mode, input way, input value,
                    input way_empty, output ready);
endinterface

`default_nettype wire

// ===== rtl/kms_out_if.sv =====
`default_nettype none

interface kms_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [kms_pkg::VALUE_W-1:0] smallest;
    logic [kms_pkg::WAY_W-1:0]          source_way;
    logic                               all_done;

    modport source (output valid, output smallest, output source_way,
                    output all_done, input ready);
    modport sink   (input valid, input smallest, input source_way,
                    input all_done, output ready);
endinterface

`default_nettype wire

// ===== rtl/kms_ctrl.sv =====
`default_nettype none

module kms_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_mode,
    output logic                    in_ready,
    input  wire logic               out_ready,
    input  wire kms_pkg::ctrl_sts_t sts,
    output kms_pkg::ctrl_cmd_t      cmd
);

    kms_pkg::state_t state_reg;
    kms_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kms_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            kms_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && (in_mode == kms_pkg::MODE_POP))
                begin
                    cmd.scan_clear = 1'b1;
                    state_next     = kms_pkg::ST_SCAN;
                end
                else if (in_valid)
                begin
                    cmd.load = 1'b1;
                end
            end
            kms_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = kms_pkg::ST_DRAIN;
                end
            end
            kms_pkg::ST_DRAIN:
            begin
                // last compare settles this cycle
                state_next = kms_pkg::ST_EMIT;
            end
            kms_pkg::ST_EMIT:
            begin
                if (!sts.out_full || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = kms_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kms_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/kms_datapath.sv =====
`default_nettype none

module kms_datapath #(
    parameter int WAYS = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [kms_pkg::CFG_W-1:0]          cfg_wdata,
    input  wire logic [kms_pkg::WAY_W-1:0]          in_way,
    input  wire logic signed [kms_pkg::VALUE_W-1:0] in_value,
    input  wire logic                               in_way_empty,
    input  wire logic                               out_ready,
    output logic                                    out_valid,
    output logic signed [kms_pkg::VALUE_W-1:0]      out_smallest,
    output logic [kms_pkg::WAY_W-1:0]               out_source_way,
    output logic                                    out_all_done,
    input  wire kms_pkg::ctrl_cmd_t                 cmd,
    output kms_pkg::ctrl_sts_t                      sts
);

    localparam int IDXW = $clog2(WAYS);
    localparam int CNTW = $clog2(WAYS + 1);

    logic [kms_pkg::CFG_W-1:0]          ways_reg;
    logic [WAYS-1:0]                    valid_reg;
    logic signed [kms_pkg::VALUE_W-1:0] head_mem [WAYS];
    logic signed [kms_pkg::VALUE_W-1:0] rd_data_reg;
    logic                               rd_live_reg;
    logic [IDXW-1:0]                    rd_idx_reg;
    logic [CNTW-1:0]                    idx_reg;
    logic [CNTW-1:0]                    limit;
    logic                               issue;
    logic                               load_ok;
    logic [IDXW-1:0]                    wr_addr;
    logic                               found_reg;
    logic signed [kms_pkg::VALUE_W-1:0] best_val_reg;
    logic [IDXW-1:0]                    best_idx_reg;
    logic                               take;
    logic                               out_valid_reg;
    logic signed [kms_pkg::VALUE_W-1:0] smallest_reg;
    logic [kms_pkg::WAY_W-1:0]          source_way_reg;
    logic                               all_done_reg;

    // clamp the search range to the ways that exist
    always_comb
    begin
        if (32'(ways_reg) >= 32'(WAYS))
        begin
            limit = CNTW'(WAYS);
        end
        else
        begin
            limit = CNTW'(ways_reg);
        end
    end

    assign issue   = cmd.scan_step && (idx_reg < limit);
    assign load_ok = cmd.load && (32'(in_way) < 32'(WAYS));
    assign wr_addr = IDXW'(in_way);
    assign take    = rd_live_reg && (!found_reg || (rd_data_reg < best_val_reg));

    assign sts.scan_last = ((CNTW + 1)'(idx_reg) + (CNTW + 1)'(1)) >= (CNTW + 1)'(limit);
    assign sts.out_full  = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ways_reg <= kms_pkg::WAYS_IN_USE_RST;
        end
        else if (cfg_we)
        begin
            ways_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (load_ok)
        begin
            valid_reg[wr_addr] <= !in_way_empty;
        end
        else if (cmd.emit && found_reg)
        begin
            valid_reg[best_idx_reg] <= 1'b0;
        end
    end

    // head store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (load_ok && !in_way_empty)
        begin
            head_mem[wr_addr] <= in_value;
        end
        rd_data_reg <= head_mem[idx_reg[IDXW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            rd_live_reg <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            rd_live_reg <= issue && valid_reg[idx_reg[IDXW-1:0]];
            if (cmd.scan_clear)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    idx_reg <= idx_reg + CNTW'(1);
                end
                if (take)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= idx_reg[IDXW-1:0];
        if (take)
        begin
            best_val_reg <= rd_data_reg;
            best_idx_reg <= rd_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            all_done_reg <= !found_reg;
            if (found_reg)
            begin
                smallest_reg   <= best_val_reg;
                source_way_reg <= kms_pkg::WAY_W'(best_idx_reg);
            end
            else
            begin
                smallest_reg   <= '0;
                source_way_reg <= '0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_smallest   = smallest_reg;
    assign out_source_way = source_way_reg;
    assign out_all_done   = all_done_reg;

endmodule

`default_nettype wire

// ===== rtl/kway_merge_select.sv =====
// K-way merge selector.
// items (sink): each beat is a load or a pop. A load (mode 0) writes value
//   as the new head of way, or, with way_empty set, marks that way spent.
//   Loads to a way the block does not have are dropped. A load leaves the
//   block idle, so it is ready again at once.
// A pop (mode 1) scans the heads of ways 0 .. limit-1, where limit is
//   ways_in_use capped at WAYS, one way per cycle through a single
//   comparator, and keeps the smallest signed head, lowest way on a tie.
//   A pop takes the beat, reads the heads of the ways in use (one idle scan
//   step when limit is zero), settles the last compare, then writes the
//   result.
// results (source): one beat per pop with smallest, source_way and
//   all_done. The winning way loses its head until it is loaded again. With
//   no live head all_done is set and the other fields are zero.
// The result sits in an output register; while the receiver stalls, loads
//   are still taken, and a following pop scans but holds its result until
//   the register frees.
// cfg_we / cfg_wdata write ways_in_use; write it only while the block idles.
// Reset clears every head's live mark and sets ways_in_use to 16.
`default_nettype none

module kway_merge_select #(
    parameter int WAYS = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [kms_pkg::CFG_W-1:0] cfg_wdata,
    kms_in_if.sink                         items,
    kms_out_if.source                      results
);

    kms_pkg::ctrl_cmd_t cmd;
    kms_pkg::ctrl_sts_t sts;

    // sequencing: idle / scan / drain / emit
    kms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .in_mode   (items.mode),
        .in_ready  (items.ready),
        .out_ready (results.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // head store, live marks, comparator and result register
    kms_datapath #(
        .WAYS (WAYS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_way         (items.way),
        .in_value       (items.value),
        .in_way_empty   (items.way_empty),
        .out_ready      (results.ready),
        .out_valid      (results.valid),
        .out_smallest   (results.smallest),
        .out_source_way (results.source_way),
        .out_all_done   (results.all_done),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule

`default_nettype wire

// ===== rtl/kms_checker.sv =====
`default_nettype none

module kms_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               in_valid,
    input wire logic                               in_ready,
    input wire logic                               in_mode,
    input wire logic                               out_valid,
    input wire logic                               out_ready,
    input wire logic signed [kms_pkg::VALUE_W-1:0] out_smallest,
    input wire logic [kms_pkg::WAY_W-1:0]          out_source_way,
    input wire logic                               out_all_done
);

    // a pop holds off further beats while it scans
    a_pop_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_mode == kms_pkg::MODE_POP)) |=> !in_ready)
        else $error("input ready after pop beat");

    // a load never stalls the next beat
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_mode == kms_pkg::MODE_LOAD)) |=> in_ready)
        else $error("input stalled after load beat");

    // a done result carries zero fields
    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_all_done) |-> ((out_smallest == '0) && (out_source_way == '0)))
        else $error("done result with non-zero fields");

    // a stalled result stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");

endmodule

bind kway_merge_select kms_checker u_kms_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (items.valid),
    .in_ready       (items.ready),
    .in_mode        (items.mode),
    .out_valid      (results.valid),
    .out_ready      (results.ready),
    .out_smallest   (results.smallest),
    .out_source_way (results.source_way),
    .out_all_done   (results.all_done)
);

`default_nettype wire
